>>> rtl/bcrs_pkg.sv
// ----------------------------------------------------------------------------
// bcrs_pkg
// Shared types and constants of the bigram count roulette sampler.
// ----------------------------------------------------------------------------
package bcrs_pkg;

	localparam int TOK_W = 8;
	localparam int RND_W = 24;
	localparam int SUM_W = 24;
	localparam int TIU_W = 9;

	localparam logic [TOK_W-1:0] START_ID = 8'd0;
	localparam logic [TOK_W-1:0] END_ID   = 8'd1;
	localparam logic [SUM_W-1:0] SUM_MAX  = 24'hFFFFFF;

	localparam logic [1:0] POS_FIRST = 2'd0;
	localparam logic [1:0] POS_LAST  = 2'd2;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_BRD   = 9'b000000100,
		ST_BWR   = 9'b000001000,
		ST_SRD   = 9'b000010000,
		ST_SSUM  = 9'b000100000,
		ST_SDIV  = 9'b001000000,
		ST_SCAN  = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

endpackage

>>> rtl/bcrs_div.sv
// ----------------------------------------------------------------------------
// bcrs_div
// Restoring remainder unit: one quotient bit per cycle; only the remainder is output.
// ----------------------------------------------------------------------------
module bcrs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bcrs_pkg::RND_W-1:0]  dividend,
	input  logic [bcrs_pkg::SUM_W-1:0]  divisor,
	output logic                        done,
	output logic [bcrs_pkg::SUM_W-1:0]  rem
);

	localparam int CNT_W = $clog2(bcrs_pkg::RND_W + 1);

	logic [bcrs_pkg::SUM_W-1:0] rem_q;
	logic [bcrs_pkg::RND_W-1:0] num_q;
	logic [bcrs_pkg::SUM_W-1:0] den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [bcrs_pkg::SUM_W:0]   trial;

	assign trial = {rem_q, num_q[bcrs_pkg::RND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(bcrs_pkg::RND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[bcrs_pkg::RND_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q})
				rem_q <= bcrs_pkg::SUM_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[bcrs_pkg::SUM_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/bigram_count_roulette_sampler_core.sv
// ----------------------------------------------------------------------------
// bigram_count_roulette_sampler_core
// Bigram count table with roulette-wheel sampling of the next token.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one request: action 0 loads token
// at position into the count table, action 1 samples a successor of token
// using random_value. Output channel (out_valid/out_ready) returns one
// result per request: next_token and error.
// Requests are handled one at a time. A last token does two
// read-modify-writes. A sample does a row-sum read, then runs the
// bit-serial remainder unit, then scans the row at one count-memory
// read per cycle.
// After reset the block sweeps both memories to zero, one count entry a
// cycle, with in_ready low. A finished result waits in
// the output register; a new request is accepted meanwhile, and its result
// holds in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module bigram_count_roulette_sampler_core #(
	parameter int TOKENS     = 256,
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [1:0]                  position,
	input  logic [bcrs_pkg::TOK_W-1:0]  token,
	input  logic [bcrs_pkg::RND_W-1:0]  random_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bcrs_pkg::TOK_W-1:0]  next_token,
	output logic                        error
);

	localparam int TW    = $clog2(TOKENS);
	localparam int CELLS = TOKENS * TOKENS;
	localparam int AW    = $clog2(CELLS);
	localparam int ACC_W = ((COUNT_BITS > bcrs_pkg::SUM_W) ? COUNT_BITS : bcrs_pkg::SUM_W) + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	bcrs_pkg::state_t state_q;

	logic [bcrs_pkg::TOK_W-1:0]  tok_q;
	logic [bcrs_pkg::RND_W-1:0]  rnd_q;
	logic [TW-1:0]               prev_q;
	logic [bcrs_pkg::TIU_W-1:0]  tiu_q;
	logic [TW-1:0]               brow_q, bcol_q;
	logic                        second_q;
	logic [AW-1:0]               clr_q;
	logic [bcrs_pkg::TOK_W-1:0]  res_q;
	logic                        rerr_q;
	logic                        ovalid_q;
	logic [bcrs_pkg::TOK_W-1:0]  nt_q;
	logic                        err_q;

	logic [bcrs_pkg::SUM_W:0]    limit_q;
	logic [ACC_W-1:0]            acc_q;
	logic [TW-1:0]               id_q;
	logic [TW-1:0]               left_q;
	logic                        p_s1;
	logic                        v_s1;
	logic [TW-1:0]               id_s1;

	// memories
	logic [COUNT_BITS-1:0]       cnt_mem [CELLS];
	logic [bcrs_pkg::SUM_W-1:0]  sum_mem [TOKENS];
	logic [COUNT_BITS-1:0]       cnt_rd_q;
	logic [bcrs_pkg::SUM_W-1:0]  sum_rd_q;

	logic                        cnt_we, sum_we;
	logic [AW-1:0]               cnt_wa, cnt_ra;
	logic [TW-1:0]               sum_wa, sum_ra;
	logic [COUNT_BITS-1:0]       cnt_wd;
	logic [bcrs_pkg::SUM_W-1:0]  sum_wd;

	logic                        div_start, div_done;
	logic [bcrs_pkg::SUM_W-1:0]  div_rem;

	logic [TW-1:0]               tok_i, tok_r, id_start;
	logic [AW-1:0]               bump_addr, scan_addr;
	logic [ACC_W-1:0]            acc_nxt;
	logic                        scan_hit;
	logic                        accept, out_free;

	function automatic logic [TW-1:0] wrap_inc(input logic [TW-1:0] v);
		if (32'(v) == TOKENS - 1)
			return '0;
		return v + 1'b1;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == bcrs_pkg::ST_IDLE);
	assign out_free = !ovalid_q || out_ready;

	assign tok_i     = TW'(token);
	assign tok_r     = TW'(tok_q);
	assign id_start  = wrap_inc(tok_r);
	assign bump_addr = AW'(brow_q * TOKENS) + AW'(bcol_q);
	assign scan_addr = AW'(tok_r * TOKENS) + AW'(id_q);
	assign acc_nxt   = acc_q + ACC_W'(cnt_rd_q);
	assign scan_hit  = p_s1 && v_s1 && (acc_nxt >= ACC_W'(limit_q));

	assign div_start = (state_q == bcrs_pkg::ST_SSUM) && (sum_rd_q != '0);

	bcrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rnd_q),
		.divisor  (sum_rd_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		cnt_we = 1'b0;
		sum_we = 1'b0;
		cnt_wa = bump_addr;
		sum_wa = brow_q;
		cnt_wd = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + 1'b1;
		sum_wd = (sum_rd_q == bcrs_pkg::SUM_MAX) ? sum_rd_q : sum_rd_q + 1'b1;
		cnt_ra = (state_q == bcrs_pkg::ST_SCAN) ? scan_addr : bump_addr;
		sum_ra = (state_q == bcrs_pkg::ST_SRD) ? tok_r : brow_q;
		if (state_q == bcrs_pkg::ST_CLEAR) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q;
			cnt_wd = '0;
			sum_we = (32'(clr_q) < TOKENS);
			sum_wa = TW'(clr_q);
			sum_wd = '0;
		end else if (state_q == bcrs_pkg::ST_BWR) begin
			cnt_we = 1'b1;
			sum_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we)
			sum_mem[sum_wa] <= sum_wd;
		sum_rd_q <= sum_mem[sum_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bcrs_pkg::ST_CLEAR;
			clr_q    <= '0;
			prev_q   <= TW'(bcrs_pkg::START_ID);
			tiu_q    <= bcrs_pkg::TIU_W'(2);
			ovalid_q <= 1'b0;
			second_q <= 1'b0;
			p_s1     <= 1'b0;
		end else begin
			if (state_q == bcrs_pkg::ST_FIN && out_free)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				bcrs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CELLS - 1)
						state_q <= bcrs_pkg::ST_IDLE;
				end
				bcrs_pkg::ST_IDLE: begin
					if (accept) begin
						tok_q    <= token;
						rnd_q    <= random_value;
						res_q    <= token;
						rerr_q   <= (action == bcrs_pkg::ACT_LOAD) &&
							(token == bcrs_pkg::START_ID || token == bcrs_pkg::END_ID);
						second_q <= (position == bcrs_pkg::POS_LAST);
						if (action == bcrs_pkg::ACT_SAMPLE) begin
							state_q <= (32'(token) >= TOKENS) ? bcrs_pkg::ST_FIN
								: bcrs_pkg::ST_SRD;
						end else if (token == bcrs_pkg::START_ID ||
							token == bcrs_pkg::END_ID) begin
							state_q <= bcrs_pkg::ST_FIN;
						end else if (32'(token) >= TOKENS) begin
							state_q <= bcrs_pkg::ST_FIN;
						end else begin
							state_q <= bcrs_pkg::ST_BRD;
							if (position == bcrs_pkg::POS_FIRST) begin
								brow_q <= TW'(bcrs_pkg::START_ID);
								bcol_q <= tok_i;
							end else if (position == bcrs_pkg::POS_LAST) begin
								brow_q <= tok_i;
								bcol_q <= TW'(bcrs_pkg::END_ID);
							end else begin
								brow_q <= prev_q;
								bcol_q <= tok_i;
							end
						end
					end
				end
				bcrs_pkg::ST_BRD: begin
					state_q <= bcrs_pkg::ST_BWR;
				end
				bcrs_pkg::ST_BWR: begin
					if (second_q) begin
						// end symbol row gets the token as successor
						second_q <= 1'b0;
						brow_q   <= TW'(bcrs_pkg::END_ID);
						bcol_q   <= tok_r;
						state_q  <= bcrs_pkg::ST_BRD;
					end else begin
						prev_q <= tok_r;
						if (bcrs_pkg::TIU_W'(tok_q) + 1'b1 > tiu_q)
							tiu_q <= bcrs_pkg::TIU_W'(tok_q) + 1'b1;
						state_q <= bcrs_pkg::ST_FIN;
					end
				end
				bcrs_pkg::ST_SRD: begin
					state_q <= bcrs_pkg::ST_SSUM;
				end
				bcrs_pkg::ST_SSUM: begin
					state_q <= (sum_rd_q == '0) ? bcrs_pkg::ST_FIN : bcrs_pkg::ST_SDIV;
				end
				bcrs_pkg::ST_SDIV: begin
					p_s1 <= 1'b0;
					if (div_done) begin
						limit_q <= {1'b0, div_rem} + 1'b1;
						acc_q   <= '0;
						id_q    <= id_start;
						left_q  <= TW'(TOKENS - 1);
						state_q <= bcrs_pkg::ST_SCAN;
					end
				end
				bcrs_pkg::ST_SCAN: begin
					// issue one read a cycle, accumulate the one that returns
					p_s1 <= (left_q != '0) && !scan_hit;
					if (left_q != '0) begin
						id_s1  <= id_q;
						v_s1   <= (32'(id_q) < 32'(tiu_q));
						id_q   <= wrap_inc(id_q);
						left_q <= left_q - 1'b1;
					end
					if (p_s1 && v_s1) begin
						acc_q <= acc_nxt;
						if (scan_hit) begin
							res_q   <= bcrs_pkg::TOK_W'(id_s1);
							state_q <= bcrs_pkg::ST_FIN;
						end else if (left_q == '0) begin
							state_q <= bcrs_pkg::ST_FIN;
						end
					end else if (left_q == '0) begin
						state_q <= bcrs_pkg::ST_FIN;
					end
				end
				bcrs_pkg::ST_FIN: begin
					if (out_free) begin
						nt_q    <= res_q;
						err_q   <= rerr_q;
						state_q <= bcrs_pkg::ST_IDLE;
					end
				end
				default: state_q <= bcrs_pkg::ST_IDLE;
			endcase
		end
	end

	assign out_valid  = ovalid_q;
	assign next_token = nt_q;
	assign error      = err_q;

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted while busy");

	// errors only come from loads of reserved ids
	a_err_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && err_q) |-> (nt_q == bcrs_pkg::START_ID || nt_q == bcrs_pkg::END_ID))
		else $error("error flagged on a non-reserved id");

	// table size in use stays within two and the id range
	a_tiu_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tiu_q >= bcrs_pkg::TIU_W'(2)) && (tiu_q <= bcrs_pkg::TIU_W'(256)))
		else $error("tokens in use out of range");

	// running count stays below the threshold while scanning
	a_acc_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bcrs_pkg::ST_SCAN) |-> (acc_q < ACC_W'(limit_q)))
		else $error("scan passed its threshold");

endmodule
